// ===== rtl/fvc_pkg.sv =====
package fvc_pkg;

    localparam int COORD_BITS  = 16;
    localparam int PLANE_COUNT = 5;
    localparam int CORNERS     = 8;
    localparam int COEF_BITS   = 16;
    localparam int FRAC_SHIFT  = 14;
    // product 32 bits, three products plus shifted offset: 36 bits is ample
    localparam int DIST_BITS   = COORD_BITS + COEF_BITS + 4;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [CFG_IDX_BITS-1:0] REG_SHOW_ALL = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAR      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PLANE0   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_LAST     = 3'd6;

    typedef enum logic [1:0] {
        OP_POINT    = 2'd0,
        OP_SPHERE   = 2'd1,
        OP_BOX      = 2'd2,
        OP_BOX_PART = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        VIS_CULL    = 2'd0,
        VIS_PARTIAL = 2'd1,
        VIS_FULL    = 2'd2
    } t_vis;

    typedef logic signed [DIST_BITS-1:0] t_dist;

    // corner-mask pair classification
    function automatic t_vis pair_class(input logic [CORNERS-1:0] m1,
                                        input logic [CORNERS-1:0] m2);
        logic all1, none1, all2, none2;
        t_vis v;
        all1  = &m1;
        none1 = ~|m1;
        all2  = &m2;
        none2 = ~|m2;
        if ((all1 && none2) || (none1 && all2)) begin
            v = VIS_CULL;
        end else if (all1 && all2) begin
            v = VIS_FULL;
        end else begin
            v = VIS_PARTIAL;
        end
        return v;
    endfunction

endpackage

// ===== rtl/frustum_visibility_classifier.sv =====
// Channel  | dir | payload
// s_axis   | in  | tdata: operation, first_x/y/z, second_x/y/z, radius (113 bits -> 120)
// m_axis   | out | tdata: visibility (2 bits -> 8)
// cfg      | in  | i_cfg_we, i_cfg_idx, i_cfg_data (64 bits)
//
// Four register stages: products, partial sums, distances, then compares into
// the output register, which is the fourth stage. One transaction per cycle
// while the output is not stalled.
// The whole pipe advances only when the output register is free or taken,
// so a stall freezes every stage and loses nothing.
// Reset (synchronous, active low) clears valid bits, the output and the
// configuration registers; data stages are left as they are.
module frustum_visibility_classifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [1:0] operation, [17:2] first_x, [33:18] first_y, [49:34] first_z,
    // [65:50] second_x, [81:66] second_y, [97:82] second_z, [112:98] radius
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] visibility
    output logic [7:0]   m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [fvc_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [fvc_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CB = fvc_pkg::COORD_BITS;
    localparam int DB = fvc_pkg::DIST_BITS;
    localparam int PB = CB + fvc_pkg::COEF_BITS;
    localparam int NP = fvc_pkg::PLANE_COUNT;
    localparam int NC = fvc_pkg::CORNERS;

    // configuration
    logic                r_show_all;
    logic [CB-2:0]       r_far;
    logic [63:0]         r_plane [NP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_show_all <= 1'b0;
            r_far      <= '0;
            for (int p = 0; p < NP; p++) r_plane[p] <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == fvc_pkg::REG_SHOW_ALL) begin
                r_show_all <= i_cfg_data[0];
            end else if (i_cfg_idx == fvc_pkg::REG_FAR) begin
                r_far <= i_cfg_data[CB-2:0];
            end else if (i_cfg_idx >= fvc_pkg::REG_PLANE0 &&
                         i_cfg_idx <= fvc_pkg::REG_LAST) begin
                r_plane[i_cfg_idx - fvc_pkg::REG_PLANE0] <= i_cfg_data;
            end
        end
    end

    // pipeline advance
    logic w_adv;
    logic r_v1, r_v2, r_v3;
    assign w_adv         = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_adv;

    // input unpack
    logic [1:0]          w_op;
    logic signed [CB-1:0] w_lo [3];
    logic signed [CB-1:0] w_hi [3];
    logic [CB-2:0]       w_rad;
    assign w_op  = s_axis_tdata[1:0];
    assign w_lo[0] = s_axis_tdata[17:2];
    assign w_lo[1] = s_axis_tdata[33:18];
    assign w_lo[2] = s_axis_tdata[49:34];
    assign w_hi[0] = s_axis_tdata[65:50];
    assign w_hi[1] = s_axis_tdata[81:66];
    assign w_hi[2] = s_axis_tdata[97:82];
    assign w_rad   = s_axis_tdata[112:98];

    // stage 1: per plane and axis, products with lo and hi
    logic signed [PB-1:0] r_plo [NP][3];
    logic signed [PB-1:0] r_phi [NP][3];
    logic [1:0]           r_op1;
    logic [CB-2:0]        r_rad1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op1  <= w_op;
            r_rad1 <= w_rad;
            for (int p = 0; p < NP; p++) begin
                for (int a = 0; a < 3; a++) begin
                    r_plo[p][a] <= $signed(r_plane[p][16*a +: 16]) * w_lo[a];
                    r_phi[p][a] <= $signed(r_plane[p][16*a +: 16]) * w_hi[a];
                end
            end
        end
    end

    // stage 2: per corner x+y partial, z plus offset partial
    logic signed [DB-1:0] r_sxy [NP][4];
    logic signed [DB-1:0] r_szd [NP][2];
    logic [1:0]           r_op2;
    logic [CB-2:0]        r_rad2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_adv) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op2  <= r_op1;
            r_rad2 <= r_rad1;
            for (int p = 0; p < NP; p++) begin
                for (int j = 0; j < 4; j++) begin
                    r_sxy[p][j] <= DB'(j[1] ? r_phi[p][0] : r_plo[p][0])
                                 + DB'(j[0] ? r_phi[p][1] : r_plo[p][1]);
                end
                r_szd[p][0] <= DB'(r_plo[p][2])
                             + (DB'($signed(r_plane[p][63:48])) <<< fvc_pkg::FRAC_SHIFT);
                r_szd[p][1] <= DB'(r_phi[p][2])
                             + (DB'($signed(r_plane[p][63:48])) <<< fvc_pkg::FRAC_SHIFT);
            end
        end
    end

    // stage 3: full distances per plane and corner (corner k: x=k[2], y=k[1], z=k[0])
    fvc_pkg::t_dist r_d [NP][NC];
    logic [1:0]     r_op3;
    fvc_pkg::t_dist r_rad3;
    fvc_pkg::t_dist r_far3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_op3  <= r_op2;
            r_rad3 <= DB'({1'b0, r_rad2}) <<< fvc_pkg::FRAC_SHIFT;
            r_far3 <= DB'({1'b0, r_far})  <<< fvc_pkg::FRAC_SHIFT;
            for (int p = 0; p < NP; p++) begin
                for (int k = 0; k < NC; k++) begin
                    r_d[p][k] <= r_sxy[p][k >> 1] + r_szd[p][k & 1];
                end
            end
        end
    end

    // stage 4: compares and classification
    fvc_pkg::t_vis w_vis;
    always_comb begin
        logic [NC-1:0] m [NP];
        logic [NC-1:0] farm;
        logic          cull, part;
        fvc_pkg::t_vis r0, r1, r2, bx;
        for (int p = 0; p < NP; p++) begin
            for (int k = 0; k < NC; k++) m[p][k] = r_d[p][k] > 0;
        end
        for (int k = 0; k < NC; k++) farm[k] = r_d[0][k] < r_far3;
        r0 = fvc_pkg::pair_class(m[1], m[2]);
        r1 = fvc_pkg::pair_class(m[3], m[4]);
        r2 = fvc_pkg::pair_class(m[0], farm);
        if (r0 == fvc_pkg::VIS_CULL || r1 == fvc_pkg::VIS_CULL ||
            r2 == fvc_pkg::VIS_CULL) begin
            bx = fvc_pkg::VIS_CULL;
        end else if (r_op3 == fvc_pkg::OP_BOX_PART) begin
            bx = fvc_pkg::VIS_PARTIAL;
        end else if (r0 == fvc_pkg::VIS_FULL && r1 == fvc_pkg::VIS_FULL &&
                     r2 == fvc_pkg::VIS_FULL) begin
            bx = fvc_pkg::VIS_FULL;
        end else begin
            bx = fvc_pkg::VIS_PARTIAL;
        end
        // point and sphere use corner zero (the first point)
        cull = (r_d[0][0] < -r_rad3) || (r_d[0][0] > r_far3 + r_rad3);
        part = (r_d[0][0] <= 0) || (r_d[0][0] >= r_far3);
        for (int p = 1; p < NP; p++) begin
            if (r_d[p][0] < -r_rad3) cull = 1'b1;
            if (r_d[p][0] <= 0)      part = 1'b1;
        end
        if (r_show_all) begin
            w_vis = (r_op3 == fvc_pkg::OP_BOX_PART) ? fvc_pkg::VIS_PARTIAL
                                                    : fvc_pkg::VIS_FULL;
        end else begin
            case (r_op3)
                fvc_pkg::OP_POINT: begin
                    w_vis = ((r_d[0][0] < 0) || (r_d[0][0] > r_far3) ||
                             (r_d[1][0] < 0) || (r_d[2][0] < 0) ||
                             (r_d[3][0] < 0) || (r_d[4][0] < 0))
                            ? fvc_pkg::VIS_CULL : fvc_pkg::VIS_FULL;
                end
                fvc_pkg::OP_SPHERE: begin
                    w_vis = cull ? fvc_pkg::VIS_CULL :
                            (part ? fvc_pkg::VIS_PARTIAL : fvc_pkg::VIS_FULL);
                end
                default: begin
                    w_vis = bx;
                end
            endcase
        end
    end

    // output register
    logic [1:0] r_vis;
    logic       r_ov;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_vis <= '0;
        end else if (w_adv) begin
            r_ov  <= r_v3;
            r_vis <= w_vis;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {6'd0, r_vis};

endmodule
